// ----- rtl/core/ps2md_pkg.sv -----
// shared types and constants for the ps2 mouse packet decoder
`timescale 1ns / 1ps

package ps2md_pkg;

    // controller status must show output full and auxiliary data
    localparam logic [7:0] STATUS_NEED = 8'h21;
    localparam int SYNC_BIT  = 3;
    localparam int X_OVF_BIT = 6;
    localparam int Y_OVF_BIT = 7;
    localparam int NUM_BUTTONS = 3;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 88;
    localparam int OUT_USER_W = 2;

    typedef enum logic [1:0] {
        KIND_MOVE    = 2'd0,
        KIND_PRESS   = 2'd1,
        KIND_RELEASE = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        POS_FIRST  = 3'b001,
        POS_SECOND = 3'b010,
        POS_THIRD  = 3'b100
    } pos_t;

    // one completed packet that gives at least one result
    typedef struct packed {
        logic                   has_move;
        logic [NUM_BUTTONS-1:0] btn_changed;
        logic [NUM_BUTTONS-1:0] btn_now;
        logic signed [7:0]      delta_x;
        logic signed [8:0]      delta_y;
        logic [31:0]            total_x;
        logic [31:0]            total_y;
    } pkt_t;

    typedef struct packed {
        logic empty;
        logic full;
    } qstat_t;

endpackage

// ----- rtl/core/ps2_mouse_packet_decoder_unit.sv -----
// top level of the ps2 mouse three-byte packet decoder
//
//   port group  dir  tdata fields (low bit up)                   sideband
//   s_*         in   status_byte, data_byte                      -
//   m_*         out  delta_x, delta_y, button_number,            tuser: event_kind
//                    total_x, total_y                            tlast: last
//   cfg_*       in   events_enabled                              -
//
// the front end takes one request per cycle while the packet queue has room
// a completed packet gives zero to four results, sent one per cycle from the
// output register unless the output stalls; the third byte writes a packet
// into the queue, and it stays there until its last result is registered
// aresetn is synchronous; it clears framing, button state, sums and the queue
// either side may stall; the queue and output register decouple the two
`timescale 1ns / 1ps

module ps2_mouse_packet_decoder_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic                                cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // status_byte [7:0], data_byte [15:8]
    input  logic [ps2md_pkg::IN_DATA_W-1:0]     s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // delta_x [7:0], delta_y [16:8], button_number [18:17],
    // total_x [50:19], total_y [82:51], zero fill above
    output logic [ps2md_pkg::OUT_DATA_W-1:0]    m_tdata,
    // event_kind [1:0]
    output logic [ps2md_pkg::OUT_USER_W-1:0]    m_tuser,
    output logic                                m_tlast
);

    logic                 push, pop;
    ps2md_pkg::pkt_t      push_data, head;
    ps2md_pkg::qstat_t    q_stat;
    ps2md_pkg::kind_t     out_kind;
    logic signed [7:0]    out_dx;
    logic signed [8:0]    out_dy;
    logic [1:0]           out_button;
    logic [31:0]          out_total_x, out_total_y;

    ps2md_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .req_valid   (s_tvalid),
        .status_byte (s_tdata[7:0]),
        .data_byte   (s_tdata[15:8]),
        .q_stat      (q_stat),
        .req_ready   (s_tready),
        .push        (push),
        .push_data   (push_data)
    );

    ps2md_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .q_stat    (q_stat)
    );

    ps2md_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .head        (head),
        .q_stat      (q_stat),
        .pop         (pop),
        .out_ready   (m_tready),
        .out_valid   (m_tvalid),
        .out_kind    (out_kind),
        .out_dx      (out_dx),
        .out_dy      (out_dy),
        .out_button  (out_button),
        .out_total_x (out_total_x),
        .out_total_y (out_total_y),
        .out_last    (m_tlast)
    );

    assign m_tdata = {5'd0, out_total_y, out_total_x, out_button, out_dy, out_dx};
    assign m_tuser = out_kind;

endmodule

// ----- rtl/core/ps2md_front.sv -----
// front end: status check, packet framing, delta and running sum update
`timescale 1ns / 1ps

module ps2md_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic                 cfg_wdata,
    input  logic                 req_valid,
    input  logic [7:0]           status_byte,
    input  logic [7:0]           data_byte,
    input  ps2md_pkg::qstat_t    q_stat,
    output logic                 req_ready,
    output logic                 push,
    output ps2md_pkg::pkt_t      push_data
);

    logic                 en_reg, en_next;
    ps2md_pkg::pos_t      pos_reg, pos_next;
    logic [7:0]           byte0_reg, byte0_next;
    logic [7:0]           byte1_reg, byte1_next;
    logic [2:0]           btn_reg, btn_next;
    logic [31:0]          sum_x_reg, sum_x_next;
    logic [31:0]          sum_y_reg, sum_y_next;

    logic                 take;
    logic                 has_move;
    logic signed [7:0]    dx;
    logic signed [8:0]    dy;
    logic [8:0]           y_ext;
    logic [2:0]           changed;

    assign req_ready = !q_stat.full;
    assign take = req_valid && req_ready && en_reg
                  && ((status_byte & ps2md_pkg::STATUS_NEED) == ps2md_pkg::STATUS_NEED);

    always_comb begin
        has_move = (byte1_reg != 8'd0) || (data_byte != 8'd0);
        dx       = byte0_reg[ps2md_pkg::X_OVF_BIT] ? 8'sd0 : $signed(byte1_reg);
        y_ext    = {data_byte[7], data_byte};
        dy       = byte0_reg[ps2md_pkg::Y_OVF_BIT] ? 9'sd0 : $signed(9'(-y_ext));
        changed  = byte0_reg[2:0] ^ btn_reg;
    end

    always_comb begin
        en_next    = cfg_we ? cfg_wdata : en_reg;
        pos_next   = pos_reg;
        byte0_next = byte0_reg;
        byte1_next = byte1_reg;
        btn_next   = btn_reg;
        sum_x_next = sum_x_reg;
        sum_y_next = sum_y_reg;
        push       = 1'b0;
        if (take) begin
            unique case (pos_reg)
                ps2md_pkg::POS_FIRST: begin
                    // lost sync: a first byte without the sync bit is dropped
                    if (data_byte[ps2md_pkg::SYNC_BIT]) begin
                        byte0_next = data_byte;
                        pos_next   = ps2md_pkg::POS_SECOND;
                    end
                end
                ps2md_pkg::POS_SECOND: begin
                    byte1_next = data_byte;
                    pos_next   = ps2md_pkg::POS_THIRD;
                end
                ps2md_pkg::POS_THIRD: begin
                    pos_next   = ps2md_pkg::POS_FIRST;
                    sum_x_next = sum_x_reg + {{24{dx[7]}}, dx};
                    sum_y_next = sum_y_reg + {{23{dy[8]}}, dy};
                    btn_next   = byte0_reg[2:0];
                    push       = has_move || (changed != 3'd0);
                end
                default: begin
                    pos_next = ps2md_pkg::POS_FIRST;
                end
            endcase
        end
    end

    always_comb begin
        push_data.has_move    = has_move;
        push_data.btn_changed = changed;
        push_data.btn_now     = byte0_reg[2:0];
        push_data.delta_x     = dx;
        push_data.delta_y     = dy;
        push_data.total_x     = sum_x_next;
        push_data.total_y     = sum_y_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            en_reg    <= 1'b1;
            pos_reg   <= ps2md_pkg::POS_FIRST;
            btn_reg   <= 3'd0;
            sum_x_reg <= 32'd0;
            sum_y_reg <= 32'd0;
        end else begin
            en_reg    <= en_next;
            pos_reg   <= pos_next;
            btn_reg   <= btn_next;
            sum_x_reg <= sum_x_next;
            sum_y_reg <= sum_y_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte0_reg <= byte0_next;
        byte1_reg <= byte1_next;
    end

endmodule

// ----- rtl/core/ps2md_queue.sv -----
// short packet queue between front end and result sequencer
`timescale 1ns / 1ps

module ps2md_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  ps2md_pkg::pkt_t      push_data,
    input  logic                 pop,
    output ps2md_pkg::pkt_t      head,
    output ps2md_pkg::qstat_t    q_stat
);

    ps2md_pkg::pkt_t                    mem [ps2md_pkg::QUEUE_DEPTH];
    logic [ps2md_pkg::QPTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [ps2md_pkg::QPTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [ps2md_pkg::QCNT_W-1:0]       cnt_reg, cnt_next;
    logic                               do_push, do_pop;

    localparam logic [ps2md_pkg::QCNT_W-1:0] FULL_CNT =
        ps2md_pkg::QCNT_W'(ps2md_pkg::QUEUE_DEPTH);
    localparam logic [ps2md_pkg::QPTR_W-1:0] LAST_PTR =
        ps2md_pkg::QPTR_W'(ps2md_pkg::QUEUE_DEPTH - 1);

    assign q_stat.empty = (cnt_reg == '0);
    assign q_stat.full  = (cnt_reg == FULL_CNT);
    assign head         = mem[rd_ptr_reg];
    assign do_push      = push && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- rtl/core/ps2md_back.sv -----
// result sequencer: expands one packet into move and button results
`timescale 1ns / 1ps

module ps2md_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ps2md_pkg::pkt_t      head,
    input  ps2md_pkg::qstat_t    q_stat,
    output logic                 pop,
    input  logic                 out_ready,
    output logic                 out_valid,
    output ps2md_pkg::kind_t     out_kind,
    output logic signed [7:0]    out_dx,
    output logic signed [8:0]    out_dy,
    output logic [1:0]           out_button,
    output logic [31:0]          out_total_x,
    output logic [31:0]          out_total_y,
    output logic                 out_last
);

    logic                 busy_reg, busy_next;
    logic [3:0]           rem_reg, rem_next;
    logic                 valid_reg, valid_next;
    ps2md_pkg::kind_t     kind_reg, kind_next;
    logic signed [7:0]    dx_reg, dx_next;
    logic signed [8:0]    dy_reg, dy_next;
    logic [1:0]           btn_reg, btn_next;
    logic [31:0]          tx_reg, tx_next;
    logic [31:0]          ty_reg, ty_next;
    logic                 last_reg, last_next;

    logic                 advance, have_work;
    logic [3:0]           cur_mask, pick, left;

    assign advance   = !valid_reg || out_ready;
    assign have_work = busy_reg || !q_stat.empty;
    // bit 0 is the move result, bits 1 to 3 the buttons in order
    assign cur_mask  = busy_reg ? rem_reg : {head.btn_changed, head.has_move};

    always_comb begin
        pick = 4'd0;
        priority if (cur_mask[0]) pick = 4'b0001;
        else if (cur_mask[1]) pick = 4'b0010;
        else if (cur_mask[2]) pick = 4'b0100;
        else if (cur_mask[3]) pick = 4'b1000;
        else pick = 4'd0;
        left = cur_mask & ~pick;
    end

    always_comb begin
        busy_next  = busy_reg;
        rem_next   = rem_reg;
        valid_next = valid_reg;
        kind_next  = kind_reg;
        dx_next    = dx_reg;
        dy_next    = dy_reg;
        btn_next   = btn_reg;
        tx_next    = tx_reg;
        ty_next    = ty_reg;
        last_next  = last_reg;
        pop        = 1'b0;
        if (advance) begin
            valid_next = have_work;
            if (have_work) begin
                busy_next = (left != 4'd0);
                rem_next  = left;
                pop       = (left == 4'd0);
                last_next = (left == 4'd0);
                tx_next   = head.total_x;
                ty_next   = head.total_y;
                dx_next   = 8'sd0;
                dy_next   = 9'sd0;
                unique case (pick)
                    4'b0001: begin
                        kind_next = ps2md_pkg::KIND_MOVE;
                        dx_next   = head.delta_x;
                        dy_next   = head.delta_y;
                        btn_next  = 2'd0;
                    end
                    4'b0010: begin
                        kind_next = head.btn_now[0] ? ps2md_pkg::KIND_PRESS
                                                    : ps2md_pkg::KIND_RELEASE;
                        btn_next  = 2'd1;
                    end
                    4'b0100: begin
                        kind_next = head.btn_now[1] ? ps2md_pkg::KIND_PRESS
                                                    : ps2md_pkg::KIND_RELEASE;
                        btn_next  = 2'd2;
                    end
                    4'b1000: begin
                        kind_next = head.btn_now[2] ? ps2md_pkg::KIND_PRESS
                                                    : ps2md_pkg::KIND_RELEASE;
                        btn_next  = 2'd3;
                    end
                    default: begin
                        kind_next = ps2md_pkg::KIND_MOVE;
                        btn_next  = 2'd0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            rem_reg   <= 4'd0;
            valid_reg <= 1'b0;
        end else begin
            busy_reg  <= busy_next;
            rem_reg   <= rem_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg <= kind_next;
        dx_reg   <= dx_next;
        dy_reg   <= dy_next;
        btn_reg  <= btn_next;
        tx_reg   <= tx_next;
        ty_reg   <= ty_next;
        last_reg <= last_next;
    end

    assign out_valid   = valid_reg;
    assign out_kind    = kind_reg;
    assign out_dx      = dx_reg;
    assign out_dy      = dy_reg;
    assign out_button  = btn_reg;
    assign out_total_x = tx_reg;
    assign out_total_y = ty_reg;
    assign out_last    = last_reg;

`ifndef SYNTHESIS
    // the packet being expanded stays at the queue head until its last result
    a_busy_has_head: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> !q_stat.empty)
        else $error("sequencer busy with empty queue");

    a_busy_has_work: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> rem_reg != 4'd0)
        else $error("sequencer busy with nothing left");

    a_button_no_delta: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && kind_reg != ps2md_pkg::KIND_MOVE) |->
            (dx_reg == 8'sd0 && dy_reg == 9'sd0 && btn_reg != 2'd0))
        else $error("button result carries movement");

    a_move_no_button: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && kind_reg == ps2md_pkg::KIND_MOVE) |-> btn_reg == 2'd0)
        else $error("move result carries button number");
`endif

endmodule

// ----- tb/ps2_mouse_packet_decoder_unit_tb.sv -----
// self-checking bench for the ps2 mouse packet decoder: directed table, then random packets
`timescale 1ns / 1ps

module ps2_mouse_packet_decoder_unit_tb;

    localparam int SETTLE_CYCLES = 16;
    localparam int STALL_LIMIT   = 3000;
    localparam int MAX_REPORTS   = 10;

    typedef struct packed {
        ps2md_pkg::kind_t  kind;
        logic signed [7:0] dx;
        logic signed [8:0] dy;
        logic [1:0]        button;
        logic [31:0]       total_x;
        logic [31:0]       total_y;
        logic              last;
    } mouse_event_t;

    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_NONE,
        CHK_TYPED
    } row_check_t;

    typedef struct packed {
        logic [7:0]   status;
        logic [7:0]   data;
        row_check_t   check;
        mouse_event_t ev;
    } stim_row_t;

    localparam mouse_event_t NO_EVENT = '0;

    localparam stim_row_t DIRECTED [22] = '{
        // status not ready in several ways
        '{8'h00, 8'hFF, CHK_NONE, NO_EVENT},
        '{8'h20, 8'h08, CHK_NONE, NO_EVENT},
        '{8'h01, 8'h08, CHK_NONE, NO_EVENT},
        // first byte without sync bit is dropped
        '{8'h21, 8'h00, CHK_NONE, NO_EVENT},
        // largest x, y of -128 turns into +128
        '{8'h21, 8'h08, CHK_NONE, NO_EVENT},
        '{8'h21, 8'h7F, CHK_NONE, NO_EVENT},
        '{8'h21, 8'h80, CHK_TYPED,
          '{ps2md_pkg::KIND_MOVE, 8'sd127, 9'sd128, 2'd0, 32'd127, 32'd128, 1'b1}},
        // zero deltas, button 1 pressed only
        '{8'hFF, 8'h09, CHK_NONE, NO_EVENT},
        '{8'h21, 8'h00, CHK_NONE, NO_EVENT},
        '{8'h21, 8'h00, CHK_TYPED,
          '{ps2md_pkg::KIND_PRESS, 8'sd0, 9'sd0, 2'd1, 32'd127, 32'd128, 1'b1}},
        // both overflow bits with nonzero raw bytes, buttons 2 and 3 pressed
        '{8'h21, 8'hCF, CHK_NONE, NO_EVENT},
        '{8'h21, 8'h80, CHK_NONE, NO_EVENT},
        '{8'h21, 8'h01, CHK_MODEL, NO_EVENT},
        // all three released
        '{8'h21, 8'h08, CHK_NONE, NO_EVENT},
        '{8'h21, 8'h00, CHK_NONE, NO_EVENT},
        '{8'h21, 8'h00, CHK_MODEL, NO_EVENT},
        // empty packet
        '{8'h21, 8'h08, CHK_NONE, NO_EVENT},
        '{8'h21, 8'h00, CHK_NONE, NO_EVENT},
        '{8'h21, 8'h00, CHK_NONE, NO_EVENT},
        // most negative deltas plus three presses
        '{8'h21, 8'h3F, CHK_NONE, NO_EVENT},
        '{8'h21, 8'h80, CHK_NONE, NO_EVENT},
        '{8'h21, 8'h7F, CHK_MODEL, NO_EVENT}
    };

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic        cfg_wdata = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [ps2md_pkg::IN_DATA_W-1:0]  s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [ps2md_pkg::OUT_DATA_W-1:0] m_tdata;
    logic [ps2md_pkg::OUT_USER_W-1:0] m_tuser;
    logic        m_tlast;

    // decoder copy
    logic                              events_on;
    ps2md_pkg::pos_t                   frame_pos;
    logic [7:0]                        first_byte;
    logic [7:0]                        second_byte;
    logic [ps2md_pkg::NUM_BUTTONS-1:0] held_buttons;
    logic [31:0]                       run_x;
    logic [31:0]                       run_y;

    mouse_event_t packet_events[$];
    mouse_event_t awaited_events[$];

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int err_count     = 0;
    int quiet_cycles  = 0;

    ps2_mouse_packet_decoder_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always #10 aclk = ~aclk;

    function automatic string event_text(mouse_event_t e);
        return $sformatf("kind %0d dx %0d dy %0d btn %0d x %0d y %0d last %0d",
                         e.kind, e.dx, e.dy, e.button, $signed(e.total_x),
                         $signed(e.total_y), e.last);
    endfunction

    function automatic void flag_error(string msg);
        err_count++;
        if (err_count <= MAX_REPORTS)
            $display("ERROR @%0t: %s", $realtime, msg);
    endfunction

    function automatic void add_event(ps2md_pkg::kind_t kind, logic signed [7:0] dx,
                                      logic signed [8:0] dy, logic [1:0] button);
        mouse_event_t ev;
        ev.kind    = kind;
        ev.dx      = dx;
        ev.dy      = dy;
        ev.button  = button;
        ev.total_x = run_x;
        ev.total_y = run_y;
        ev.last    = 1'b0;
        packet_events.push_back(ev);
    endfunction

    // one byte through the framer; completed packets leave their events in packet_events
    function automatic void decode_byte(logic [7:0] status, logic [7:0] data);
        logic signed [7:0] dx;
        logic signed [8:0] dy;
        packet_events.delete();
        if ((status & ps2md_pkg::STATUS_NEED) != ps2md_pkg::STATUS_NEED || !events_on)
            return;
        case (frame_pos)
            ps2md_pkg::POS_FIRST: begin
                if (data[ps2md_pkg::SYNC_BIT]) begin
                    first_byte = data;
                    frame_pos  = ps2md_pkg::POS_SECOND;
                end
            end
            ps2md_pkg::POS_SECOND: begin
                second_byte = data;
                frame_pos   = ps2md_pkg::POS_THIRD;
            end
            default: begin
                frame_pos = ps2md_pkg::POS_FIRST;
                if (second_byte != 8'd0 || data != 8'd0) begin
                    dx = first_byte[ps2md_pkg::X_OVF_BIT] ? 8'sd0 : $signed(second_byte);
                    dy = first_byte[ps2md_pkg::Y_OVF_BIT] ? 9'sd0
                                                          : -$signed({data[7], data});
                    run_x = run_x + {{24{dx[7]}}, dx};
                    run_y = run_y + {{23{dy[8]}}, dy};
                    add_event(ps2md_pkg::KIND_MOVE, dx, dy, 2'd0);
                end
                for (int i = 0; i < ps2md_pkg::NUM_BUTTONS; i++) begin
                    if (first_byte[i] != held_buttons[i])
                        add_event(held_buttons[i] ? ps2md_pkg::KIND_RELEASE
                                                  : ps2md_pkg::KIND_PRESS,
                                  8'sd0, 9'sd0, 2'(i + 1));
                end
                held_buttons = first_byte[ps2md_pkg::NUM_BUTTONS-1:0];
                if (packet_events.size() > 0)
                    packet_events[packet_events.size()-1].last = 1'b1;
            end
        endcase
    endfunction

    task automatic send_request(input logic [7:0] status, input logic [7:0] data,
                                input bit use_model);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {data, status};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        decode_byte(status, data);
        if (use_model)
            foreach (packet_events[i])
                awaited_events.push_back(packet_events[i]);
    endtask

    task automatic drain_and_settle();
        s_tvalid <= 1'b0;
        while (awaited_events.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_events_enabled(input logic value);
        drain_and_settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        events_on = value;
    endtask

    function automatic logic [7:0] ready_status();
        return 8'($urandom_range(255)) | ps2md_pkg::STATUS_NEED;
    endfunction

    // mostly well-formed packets with random content, some noise items between them
    task automatic stream_packets(input int n_items);
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        int sent;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(7) == 0) begin
                send_request(8'($urandom_range(255)), 8'($urandom_range(255)), 1'b1);
                sent++;
            end else begin
                b0 = 8'($urandom_range(255));
                if ($urandom_range(9) != 0)
                    b0[ps2md_pkg::SYNC_BIT] = 1'b1;
                b0[ps2md_pkg::X_OVF_BIT] = ($urandom_range(3) == 0);
                b0[ps2md_pkg::Y_OVF_BIT] = ($urandom_range(3) == 0);
                b1 = ($urandom_range(3) == 0) ? 8'd0 : 8'($urandom_range(255));
                b2 = ($urandom_range(3) == 0) ? 8'd0 : 8'($urandom_range(255));
                send_request(ready_status(), b0, 1'b1);
                send_request(ready_status(), b1, 1'b1);
                send_request(ready_status(), b2, 1'b1);
                sent += 3;
            end
        end
    endtask

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // result checker
    always @(posedge aclk) begin
        mouse_event_t got;
        mouse_event_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.kind    = ps2md_pkg::kind_t'(m_tuser);
            got.dx      = m_tdata[7:0];
            got.dy      = m_tdata[16:8];
            got.button  = m_tdata[18:17];
            got.total_x = m_tdata[50:19];
            got.total_y = m_tdata[82:51];
            got.last    = m_tlast;
            if (awaited_events.size() == 0) begin
                flag_error({"unexpected result: ", event_text(got)});
            end else begin
                want = awaited_events.pop_front();
                if (got !== want)
                    flag_error({"expected ", event_text(want), " got ", event_text(got)});
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no request moved for %0d cycles", STALL_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        events_on    = 1'b1;
        frame_pos    = ps2md_pkg::POS_FIRST;
        first_byte   = '0;
        second_byte  = '0;
        held_buttons = '0;
        run_x        = '0;
        run_y        = '0;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (DIRECTED[i]) begin
            send_request(DIRECTED[i].status, DIRECTED[i].data,
                         DIRECTED[i].check == CHK_MODEL);
            if (DIRECTED[i].check == CHK_TYPED)
                awaited_events.push_back(DIRECTED[i].ev);
        end

        write_events_enabled(1'b1);
        stream_packets(81);

        send_idle_pct = 71;
        stream_packets(81);

        // everything is discarded while disabled, framing position must hold
        write_events_enabled(1'b0);
        stream_packets(24);
        write_events_enabled(1'b1);

        send_idle_pct = 0;
        stall_pct     = 71;
        stream_packets(81);

        send_idle_pct = 12;
        stall_pct     = 12;
        stream_packets(81);

        drain_and_settle();

        if (err_count == 0 && awaited_events.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
